/* rtl/ecar_pkg.sv */
// Shared types and constants for the elementary automaton ring step block.
// No dependencies; imported by every module in rtl/.
package ecar_pkg;

  localparam int CELLS = 8;
  localparam int CNT_W = $clog2(CELLS + 1);

  typedef logic [CELLS-1:0]  cells_t;
  typedef logic signed [1:0] sign_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam sign_t SIGN_NEG  = -2'sd1;
  localparam sign_t SIGN_ZERO = 2'sd0;
  localparam sign_t SIGN_POS  = 2'sd1;

  // rule index bits: right neighbour, centre, left neighbour
  localparam int NB_RIGHT  = 0;
  localparam int NB_CENTRE = 1;
  localparam int NB_LEFT   = 2;

  typedef struct packed {
    logic             step_event;
    logic [7:0]       rule_bits;
    logic             scan_connected;
    sign_t            scan_level_sign;
    logic             scan_flip;
    logic [2*CELLS-1:0] cell_toggle_mask;
    cells_t           cell_set_mask;
  } item_t;

  typedef struct packed {
    cells_t gen_current;
    cells_t gen_previous;
    sign_t  scan_dir;
    sign_t  last_level_sign;
  } ca_state_t;

  typedef struct packed {
    cells_t number_a;
    cells_t number_b;
    cells_t number_and;
    cells_t number_xor;
    cells_t number_or;
    count_t count_a;
    count_t count_b;
    count_t count_both;
    count_t count_diff;
    count_t count_any;
    logic   scan_reversed;
  } result_t;

endpackage

/* rtl/elementary_ca_ring_step_core.sv */
// Elementary cellular automaton step on an 8-cell ring, streaming top level.
// Input transaction to result valid: input register, then result register.
// Throughput: 1 transaction per cycle while results drain; a waiting result lets one more in, then tready drops.
// Reset (rst, synchronous, active high): generations cleared, scan direction +1,
// last level 0, fun_mode 0, both pipeline registers empty. Depends on ecar_pkg, ecar_step and ecar_report.
module elementary_ca_ring_step_core (
  input  logic        clk,
  input  logic        rst,
  // configuration: fun_mode
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] step_event, [8:1] rule_bits, [9] scan_connected, [11:10] scan_level_sign,
  // [12] scan_flip, [28:13] cell_toggle_mask, [36:29] cell_set_mask, [39:37] zero
  input  logic [39:0] s_axis_tdata,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] number_a, [15:8] number_b, [23:16] number_and, [31:24] number_xor,
  // [39:32] number_or, [43:40] count_a, [47:44] count_b, [51:48] count_both,
  // [55:52] count_diff, [59:56] count_any, [60] scan_reversed, [63:61] zero
  output logic [63:0] m_axis_tdata
);
  import ecar_pkg::*;

  logic      fun_mode;
  logic      in_valid;
  item_t     in_item;
  logic      out_valid;
  result_t   out_res;
  ca_state_t state;
  ca_state_t state_next;
  result_t   res_next;
  item_t     item_unpacked;
  logic      advance;
  logic      s_acc;

  // Unpack the input transaction; field order follows the tdata comment above.
  always_comb begin
    item_unpacked.step_event       = s_axis_tdata[0];
    item_unpacked.rule_bits        = s_axis_tdata[8:1];
    item_unpacked.scan_connected   = s_axis_tdata[9];
    item_unpacked.scan_level_sign  = sign_t'(s_axis_tdata[11:10]);
    item_unpacked.scan_flip        = s_axis_tdata[12];
    item_unpacked.cell_toggle_mask = s_axis_tdata[28:13];
    item_unpacked.cell_set_mask    = s_axis_tdata[36:29];
  end

  // The held item moves on when the result register is empty or being drained.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fun_mode <= 1'b0;
    end else if (cfg_we) begin
      fun_mode <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_item <= item_unpacked;
    end
  end

  ecar_step u_step (
    .fun_mode   (fun_mode),
    .item       (in_item),
    .state_cur  (state),
    .state_next (state_next)
  );

  ecar_report u_report (
    .state_in (state_next),
    .result   (res_next)
  );

  // Automaton state commits as the item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.gen_current     <= '0;
      state.gen_previous    <= '0;
      state.scan_dir        <= SIGN_POS;
      state.last_level_sign <= SIGN_ZERO;
    end else if (in_valid && advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000,
                          out_res.scan_reversed,
                          out_res.count_any,
                          out_res.count_diff,
                          out_res.count_both,
                          out_res.count_b,
                          out_res.count_a,
                          out_res.number_or,
                          out_res.number_xor,
                          out_res.number_and,
                          out_res.number_b,
                          out_res.number_a};

`ifndef NO_ASSERTIONS
  // direction and level never take the out-of-range -2 pattern
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    state.scan_dir != 2'sb10 && state.last_level_sign != 2'sb10)
    else $error("scan state out of range");

  // |A| + |B| = |A and B| + |A or B|
  a_count_incl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_res.count_a} + {1'b0, out_res.count_b}) ==
                  ({1'b0, out_res.count_both} + {1'b0, out_res.count_any}))
    else $error("count inclusion-exclusion broken");

  // |A xor B| = |A or B| - |A and B|
  a_count_xor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_res.count_diff} + {1'b0, out_res.count_both}) ==
                  {1'b0, out_res.count_any})
    else $error("xor count inconsistent");

  // a held item is never overwritten by a new transaction
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s_acc && in_valid) |-> advance)
    else $error("input register overrun");

  // a stepped item with no previous-generation toggles leaves the old current generation as the previous one
  a_step_copy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance && in_item.step_event && in_item.cell_toggle_mask[15:8] == 8'h00)
      |=> state.gen_previous == $past(state.gen_current))
    else $error("previous generation not copied on step");
`endif

endmodule

/* rtl/ecar_step.sv */
// Next-state logic: scan direction handling, rule update of the ring, masks.
// Depends on ecar_pkg.
module ecar_step (
  input  logic               fun_mode,
  input  ecar_pkg::item_t    item,
  input  ecar_pkg::ca_state_t state_cur,
  output ecar_pkg::ca_state_t state_next
);
  import ecar_pkg::*;

  sign_t  dir_sign;
  sign_t  level;
  sign_t  dir_lvl;
  sign_t  dir_new;
  sign_t  last_new;
  cells_t old_gen;
  cells_t rule_gen;
  cells_t cur_stepped;
  cells_t prev_stepped;
  logic [2:0] nb [CELLS];

  always_comb begin
    // sign of the held direction
    if (state_cur.scan_dir[1]) begin
      dir_sign = SIGN_NEG;
    end else if (state_cur.scan_dir != SIGN_ZERO) begin
      dir_sign = SIGN_POS;
    end else begin
      dir_sign = SIGN_ZERO;
    end

    // -2 pattern counts as -1
    if (item.scan_connected) begin
      level = item.scan_level_sign[1] ? SIGN_NEG : item.scan_level_sign;
    end else begin
      level = dir_sign;
    end

    if (level != state_cur.last_level_sign) begin
      dir_lvl  = level;
      last_new = level;
    end else begin
      dir_lvl  = state_cur.scan_dir;
      last_new = state_cur.last_level_sign;
    end

    dir_new = item.scan_flip ? sign_t'(-dir_lvl) : dir_lvl;
  end

  assign old_gen = state_cur.gen_current;

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      nb[i][NB_LEFT]   = old_gen[(i == 0) ? CELLS - 1 : i - 1];
      nb[i][NB_CENTRE] = old_gen[i];
      if (i == CELLS - 1) begin
        nb[i][NB_RIGHT] = old_gen[0];
      end else begin
        nb[i][NB_RIGHT] = fun_mode ? old_gen[i] : old_gen[(i + 1) % CELLS];
      end
      rule_gen[i] = item.rule_bits[nb[i]];
    end
  end

  assign cur_stepped  = item.step_event ? rule_gen : state_cur.gen_current;
  assign prev_stepped = item.step_event ? old_gen  : state_cur.gen_previous;

  always_comb begin
    state_next.gen_current  = (cur_stepped ^ item.cell_toggle_mask[CELLS-1:0])
                              | item.cell_set_mask;
    state_next.gen_previous = prev_stepped ^ item.cell_toggle_mask[2*CELLS-1:CELLS];
    state_next.scan_dir        = dir_new;
    state_next.last_level_sign = last_new;
  end

endmodule

/* rtl/ecar_report.sv */
// Result formation: combinations of the two generations, counts, scan order.
// Depends on ecar_pkg.
module ecar_report (
  input  ecar_pkg::ca_state_t state_in,
  output ecar_pkg::result_t   result
);
  import ecar_pkg::*;

  cells_t a;
  cells_t b;
  cells_t v_and;
  cells_t v_xor;
  cells_t v_or;
  logic   rev;

  function automatic count_t popcount(cells_t v);
    count_t n;
    n = '0;
    for (int i = 0; i < CELLS; i++) begin
      n = n + count_t'(v[i]);
    end
    return n;
  endfunction

  function automatic cells_t scan_order(cells_t v, logic reversed);
    cells_t r;
    for (int i = 0; i < CELLS; i++) begin
      r[CELLS - 1 - i] = v[i];
    end
    return reversed ? r : v;
  endfunction

  assign a     = state_in.gen_current;
  assign b     = state_in.gen_previous;
  assign v_and = a & b;
  assign v_xor = a ^ b;
  assign v_or  = a | b;
  assign rev   = state_in.scan_dir[1];

  always_comb begin
    result.number_a      = scan_order(a, rev);
    result.number_b      = scan_order(b, rev);
    result.number_and    = scan_order(v_and, rev);
    result.number_xor    = scan_order(v_xor, rev);
    result.number_or     = scan_order(v_or, rev);
    result.count_a       = popcount(a);
    result.count_b       = popcount(b);
    result.count_both    = popcount(v_and);
    result.count_diff    = popcount(v_xor);
    result.count_any     = popcount(v_or);
    result.scan_reversed = rev;
  end

endmodule

/* tb/sv/elementary_ca_ring_step_core_test.sv */
// Self-checking testbench for elementary_ca_ring_step_core: the automaton ring, the scan
// direction handling and the mask updates, checked against a predictor kept in this file.
// Depends on ecar_pkg and the core RTL only.
module elementary_ca_ring_step_core_test;
  import ecar_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction on either side
  localparam int MAX_REPORTS    = 10;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  // block ports, all known from time zero
  logic        cfg_we        = 1'b0;
  logic        cfg_wdata     = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  elementary_ca_ring_step_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Ring predictor: own copy of both generations, the scan state and fun_mode.
  // ---------------------------------------------------------------------------
  cells_t ring_now;
  cells_t ring_before;
  sign_t  scan_heading;
  sign_t  level_seen;
  logic   fun_mode_shadow;

  result_t ring_expect_q[$];   // predicted results, oldest first
  int      mismatch_count = 0;
  bit      idle_on = 1'b1;     // random gaps on both sides when set
  int      rx_stall_left = 0;
  int      quiet_cycles = 0;

  // Cell i lands on bit i, or on bit CELLS-1-i when scanning backwards.
  function automatic cells_t scan_ordered(input cells_t v, input logic rev);
    cells_t r;
    r = v;
    if (rev) begin
      for (int i = 0; i < CELLS; i++) r[CELLS-1-i] = v[i];
    end
    return r;
  endfunction

  function automatic result_t advance_ring(input item_t it);
    sign_t    lvl;
    cells_t   old;
    cells_t   nxt;
    int       lft;
    int       rgt;
    logic [2:0] hood;
    cells_t   v_and;
    cells_t   v_xor;
    cells_t   v_or;
    logic     rev;
    result_t  res;
    // scan level: the -2 pattern reads as -1; unconnected keeps the present heading,
    // which is already a sign
    if (it.scan_connected) lvl = it.scan_level_sign[1] ? SIGN_NEG : it.scan_level_sign;
    else                   lvl = scan_heading;
    if (lvl != level_seen) begin
      scan_heading = lvl;
      level_seen   = lvl;
    end
    if (it.scan_flip) scan_heading = SIGN_ZERO - scan_heading;   // zero stays zero

    if (it.step_event) begin
      old         = ring_now;
      ring_before = old;
      for (int i = 0; i < CELLS; i++) begin
        lft = (i == 0) ? CELLS - 1 : i - 1;
        // in fun mode a cell is its own right neighbour, except the last one
        if (i == CELLS - 1)      rgt = 0;
        else if (fun_mode_shadow) rgt = i;
        else                      rgt = i + 1;
        hood[NB_LEFT]   = old[lft];
        hood[NB_CENTRE] = old[i];
        hood[NB_RIGHT]  = old[rgt];
        nxt[i] = it.rule_bits[hood];
      end
      ring_now = nxt;
    end

    // toggles first, then the set mask
    ring_now    = ring_now ^ it.cell_toggle_mask[CELLS-1:0];
    ring_before = ring_before ^ it.cell_toggle_mask[2*CELLS-1:CELLS];
    ring_now    = ring_now | it.cell_set_mask;

    v_and = ring_now & ring_before;
    v_xor = ring_now ^ ring_before;
    v_or  = ring_now | ring_before;
    rev   = (scan_heading == SIGN_NEG);

    res.number_a      = scan_ordered(ring_now, rev);
    res.number_b      = scan_ordered(ring_before, rev);
    res.number_and    = scan_ordered(v_and, rev);
    res.number_xor    = scan_ordered(v_xor, rev);
    res.number_or     = scan_ordered(v_or, rev);
    res.count_a       = count_t'($countones(ring_now));
    res.count_b       = count_t'($countones(ring_before));
    res.count_both    = count_t'($countones(v_and));
    res.count_diff    = count_t'($countones(v_xor));
    res.count_any     = count_t'($countones(v_or));
    res.scan_reversed = rev;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream packing helpers
  // ---------------------------------------------------------------------------
  function automatic logic [39:0] pack_item(input item_t it);
    return {3'b000, it.cell_set_mask, it.cell_toggle_mask, it.scan_flip,
            it.scan_level_sign, it.scan_connected, it.rule_bits, it.step_event};
  endfunction

  function automatic result_t unpack_result(input logic [63:0] d);
    result_t r;
    r.number_a      = d[7:0];
    r.number_b      = d[15:8];
    r.number_and    = d[23:16];
    r.number_xor    = d[31:24];
    r.number_or     = d[39:32];
    r.count_a       = d[43:40];
    r.count_b       = d[47:44];
    r.count_both    = d[51:48];
    r.count_diff    = d[55:52];
    r.count_any     = d[59:56];
    r.scan_reversed = d[60];
    return r;
  endfunction

  function automatic item_t make_item(input logic stp, input logic [7:0] rule,
                                      input logic conn, input sign_t lvl, input logic flip,
                                      input logic [15:0] tgl, input cells_t setm);
    item_t it;
    it.step_event       = stp;
    it.rule_bits        = rule;
    it.scan_connected   = conn;
    it.scan_level_sign  = lvl;
    it.scan_flip        = flip;
    it.cell_toggle_mask = tgl;
    it.cell_set_mask    = setm;
    return it;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transaction per call; valid stays high between calls with
  // no gap, so it is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_item(it);
    do @(posedge clk); while (!s_axis_tready);
    ring_expect_q.push_back(advance_ring(it));
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (ring_expect_q.size() != 0);
  endtask

  // only called with the pipeline empty
  task automatic write_fun_mode(input logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we          <= 1'b0;
    fun_mode_shadow = v;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, and the result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_stall_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      rx_stall_left <= pick_gap();
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      if (mismatch_count < MAX_REPORTS)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = unpack_result(m_axis_tdata);
      if (ring_expect_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("result transaction with nothing expected: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = ring_expect_q.pop_front();
        compare_field("number_a",      want.number_a,      got.number_a);
        compare_field("number_b",      want.number_b,      got.number_b);
        compare_field("number_and",    want.number_and,    got.number_and);
        compare_field("number_xor",    want.number_xor,    got.number_xor);
        compare_field("number_or",     want.number_or,     got.number_or);
        compare_field("count_a",       want.count_a,       got.count_a);
        compare_field("count_b",       want.count_b,       got.count_b);
        compare_field("count_both",    want.count_both,    got.count_both);
        compare_field("count_diff",    want.count_diff,    got.count_diff);
        compare_field("count_any",     want.count_any,     got.count_any);
        compare_field("scan_reversed", want.scan_reversed, got.scan_reversed);
      end
    end
  end

  // watchdog: ends a run that stops moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("elementary_ca_ring_step_core_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // all-zero item straight after reset: empty ring, forward scan
  task automatic test_reset_state();
    send_item(make_item(1'b0, 8'h00, 1'b0, SIGN_ZERO, 1'b0, 16'h0000, 8'h00));
  endtask

  // field extremes and the update order: step, toggles, then set
  task automatic test_field_extremes();
    send_item(make_item(1'b1, 8'hFF, 1'b0, SIGN_ZERO, 1'b0, 16'h0000, 8'h00)); // all live
    send_item(make_item(1'b1, 8'h00, 1'b0, SIGN_ZERO, 1'b0, 16'h0000, 8'h00)); // copy, clear
    send_item(make_item(1'b0, 8'h00, 1'b0, SIGN_ZERO, 1'b0, 16'hFFFF, 8'h00)); // flip both
    send_item(make_item(1'b1, 8'hFF, 1'b0, SIGN_ZERO, 1'b0, 16'hFFFF, 8'hFF)); // toggle then set
    send_item(make_item(1'b0, 8'h00, 1'b0, SIGN_ZERO, 1'b0, 16'h00FF, 8'h00));
    // single seed through rule 30, step held high on consecutive items (level, no edge)
    send_item(make_item(1'b0, 8'h00, 1'b0, SIGN_ZERO, 1'b0, 16'h0000, 8'h08));
    repeat (3) send_item(make_item(1'b1, 8'd30, 1'b0, SIGN_ZERO, 1'b0, 16'h0000, 8'h00));
  endtask

  // scan level, the -2 pattern, zero heading and flips
  task automatic test_scan_direction();
    send_item(make_item(1'b0, 8'h00, 1'b1, SIGN_NEG,  1'b0, 16'h0000, 8'h07));
    send_item(make_item(1'b0, 8'h00, 1'b1, SIGN_ZERO, 1'b0, 16'h0000, 8'h00)); // heading 0
    send_item(make_item(1'b0, 8'h00, 1'b1, SIGN_ZERO, 1'b1, 16'h0000, 8'h00)); // flip of 0
    send_item(make_item(1'b0, 8'h00, 1'b1, 2'b10,     1'b0, 16'h0000, 8'h00)); // -2 as -1
    send_item(make_item(1'b0, 8'h00, 1'b0, SIGN_ZERO, 1'b1, 16'h0000, 8'h00)); // flip fwd
    send_item(make_item(1'b0, 8'h00, 1'b1, SIGN_POS,  1'b1, 16'h0100, 8'h00));
    send_item(make_item(1'b0, 8'h00, 1'b0, SIGN_ZERO, 1'b0, 16'h0000, 8'h00));
  endtask

  // fun mode: right neighbour is the cell itself, the last cell still wraps to cell 0
  task automatic test_fun_mode();
    write_fun_mode(1'b1);
    send_item(make_item(1'b0, 8'h00, 1'b0, SIGN_ZERO, 1'b0, 16'h00FF, 8'h81));
    send_item(make_item(1'b1, 8'hAA, 1'b0, SIGN_ZERO, 1'b0, 16'h0000, 8'h00)); // right bit
    send_item(make_item(1'b1, 8'hAA, 1'b0, SIGN_ZERO, 1'b0, 16'h0000, 8'h01));
    send_item(make_item(1'b1, 8'd110, 1'b0, SIGN_ZERO, 1'b0, 16'h0000, 8'h00));
    send_item(make_item(1'b1, 8'hF0, 1'b1, SIGN_NEG, 1'b0, 16'h0000, 8'h00));
    write_fun_mode(1'b0);
  endtask

  // Random evolution: mostly steps with random rules; random toggle and set masks
  // land on a minority of items, stepped or not.
  task automatic test_random_evolution(input int n_items);
    item_t it;
    for (int n = 0; n < n_items; n++) begin
      it.step_event       = ($urandom_range(0, 9) < 7);
      it.rule_bits        = 8'($urandom_range(0, 255));
      it.scan_connected   = 1'($urandom_range(0, 1));
      it.scan_level_sign  = sign_t'($urandom_range(0, 3));
      it.scan_flip        = ($urandom_range(0, 7) == 0);
      it.cell_toggle_mask = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                        : 16'h0000;
      it.cell_set_mask    = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'h00;
      send_item(it);
    end
  endtask

  initial begin
    ring_now        = '0;
    ring_before     = '0;
    scan_heading    = SIGN_POS;
    level_seen      = SIGN_ZERO;
    fun_mode_shadow = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_fun_mode(1'b0);
    test_reset_state();
    test_field_extremes();
    test_scan_direction();
    test_fun_mode();

    test_random_evolution(450);
    write_fun_mode(1'b1);
    test_random_evolution(450);
    idle_on = 1'b0;             // a stretch at full rate on both sides
    test_random_evolution(400);
    write_fun_mode(1'b0);
    idle_on = 1'b1;
    test_random_evolution(450);

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("elementary_ca_ring_step_core_test: PASS");
    end else begin
      $display("elementary_ca_ring_step_core_test: FAIL");
    end
    $finish;
  end

endmodule
